// ----- src/sfob_pkg.sv -----
// Shared constants and types for the sync framed object block parser.
package sfob_pkg;

  localparam int unsigned NumSig = 7;
  localparam int unsigned SlotW  = (NumSig > 1) ? $clog2(NumSig) : 1;
  localparam int unsigned SumW   = 19;

  localparam logic [15:0] SyncWord = 16'haa55;
  localparam logic [7:0]  SyncLo   = 8'h55;
  localparam logic [7:0]  SyncHi   = 8'haa;

  localparam logic [3:0] PhaseHunt  = 4'd0;
  localparam logic [3:0] PhaseFirst = 4'd1;
  localparam logic [3:0] PhaseLast  = 4'd12;

  typedef enum logic {
    FUNC_BYTE  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    WORD_CHECKSUM  = 3'd0,
    WORD_SIGNATURE = 3'd1,
    WORD_X         = 3'd2,
    WORD_Y         = 3'd3,
    WORD_WIDTH     = 3'd4,
    WORD_HEIGHT    = 3'd5
  } word_e;

  typedef struct packed {
    logic [15:0] height;
    logic [15:0] width;
    logic [15:0] y;
    logic [15:0] x;
  } geom_t;

  typedef struct packed {
    logic             en;
    logic             good;
    logic [SlotW-1:0] slot;
    geom_t            geom;
  } store_t;

  typedef struct packed {
    logic  found;
    geom_t geom;
  } result_t;

endpackage

// ----- src/sfob_if.sv -----
// Valid/ready channel interfaces for the parser's input and result items.
interface sfob_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;
  logic [2:0] query_signature;

  modport source (output valid, func, rx_byte, query_signature, input ready);
  modport sink   (input valid, func, rx_byte, query_signature, output ready);
endinterface

interface sfob_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] obj_x;
  logic [15:0] obj_y;
  logic [15:0] obj_width;
  logic [15:0] obj_height;

  modport source (output valid, found, obj_x, obj_y, obj_width, obj_height, input ready);
  modport sink   (input valid, found, obj_x, obj_y, obj_width, obj_height, output ready);
endinterface

// ----- src/sfob_parser.sv -----
// Byte framer: sync hunt, word assembly, checksum check, store events.
module sfob_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            byte_en_i,
  input  logic [7:0]      rx_byte_i,
  output sfob_pkg::store_t store_o
);
  import sfob_pkg::*;

  logic [7:0]  prev_q, prev_d;
  logic [3:0]  phase_q, phase_d;
  logic [7:0]  low_q, low_d;
  logic        extra_q, extra_d;
  logic [15:0] chk_q, chk_d;
  logic [15:0] sig_q, sig_d;
  logic [15:0] x_q, x_d;
  logic [15:0] y_q, y_d;
  logic [15:0] wid_q, wid_d;

  logic [3:0]      pos;
  logic [15:0]     word;
  logic [SumW-1:0] sum;
  logic [15:0]     sig_m1;

  assign pos    = phase_q - PhaseFirst;
  assign word   = {rx_byte_i, low_q};
  assign sum    = SumW'(sig_q) + SumW'(x_q) + SumW'(y_q) + SumW'(wid_q) + SumW'(word);
  assign sig_m1 = sig_q - 16'd1;

  always_comb begin
    prev_d  = prev_q;
    phase_d = phase_q;
    low_d   = low_q;
    extra_d = extra_q;
    chk_d   = chk_q;
    sig_d   = sig_q;
    x_d     = x_q;
    y_d     = y_q;
    wid_d   = wid_q;
    store_o = '0;
    if (byte_en_i) begin
      if (phase_q == PhaseHunt) begin
        if (prev_q == SyncLo && rx_byte_i == SyncHi) begin
          phase_d = PhaseFirst;
          extra_d = 1'b0;
          prev_d  = 8'd0;
        end else begin
          prev_d = rx_byte_i;
        end
      end else if (phase_q > PhaseLast) begin
        phase_d = PhaseHunt;
        prev_d  = 8'd0;
      end else if (!pos[0]) begin
        low_d   = rx_byte_i;
        phase_d = phase_q + 4'd1;
      end else begin
        phase_d = phase_q + 4'd1;
        case (word_e'(pos[3:1]))
          WORD_CHECKSUM: begin
            // skip one repeated sync word
            if (word == SyncWord && !extra_q) begin
              extra_d = 1'b1;
              phase_d = PhaseFirst;
            end else begin
              chk_d = word;
            end
          end
          WORD_SIGNATURE: begin
            sig_d = word;
            if (word == 16'd0 || word > 16'(NumSig)) begin
              phase_d = PhaseHunt;
              prev_d  = 8'd0;
            end
          end
          WORD_X:     x_d   = word;
          WORD_Y:     y_d   = word;
          WORD_WIDTH: wid_d = word;
          WORD_HEIGHT: begin
            if (sig_m1 < 16'(NumSig)) begin
              store_o.en          = 1'b1;
              store_o.good        = (sum == SumW'(chk_q));
              store_o.slot        = SlotW'(sig_m1);
              store_o.geom.x      = x_q;
              store_o.geom.y      = y_q;
              store_o.geom.width  = wid_q;
              store_o.geom.height = word;
            end
            phase_d = PhaseHunt;
            prev_d  = 8'd0;
          end
          default: begin
            phase_d = PhaseHunt;
            prev_d  = 8'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      phase_q <= PhaseHunt;
      low_q   <= '0;
      extra_q <= 1'b0;
      chk_q   <= '0;
      sig_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
      wid_q   <= '0;
    end else begin
      prev_q  <= prev_d;
      phase_q <= phase_d;
      low_q   <= low_d;
      extra_q <= extra_d;
      chk_q   <= chk_d;
      sig_q   <= sig_d;
      x_q     <= x_d;
      y_q     <= y_d;
      wid_q   <= wid_d;
    end
  end

endmodule

// ----- src/sfob_table.sv -----
// Per-signature object table: store, invalidate, read-and-clear query.
module sfob_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfob_pkg::store_t  store_i,
  input  logic              query_en_i,
  input  logic [2:0]        query_signature_i,
  output sfob_pkg::result_t result_o
);
  import sfob_pkg::*;

  logic [NumSig-1:0] valid_q;
  geom_t             geom_q [NumSig];

  logic [3:0]       qm1;
  logic [SlotW-1:0] qslot;
  logic             q_in_range;

  assign qm1        = {1'b0, query_signature_i} - 4'd1;
  assign qslot      = SlotW'(qm1);
  assign q_in_range = (query_signature_i != 3'd0) && (32'(query_signature_i) <= NumSig);

  always_comb begin
    result_o = '0;
    if (q_in_range && valid_q[qslot]) begin
      result_o.found = 1'b1;
      result_o.geom  = geom_q[qslot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (store_i.en) begin
        valid_q[store_i.slot] <= store_i.good;
      end
      // clear on read
      if (query_en_i && q_in_range) begin
        valid_q[qslot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_i.en && store_i.good) begin
      geom_q[store_i.slot] <= store_i.geom;
    end
  end

endmodule

// ----- src/sync_framed_object_block_parser.sv -----
// Top level: input register, parser and object table, result register.
// Takes one item per cycle: serial bytes (func 0) are framed on the sync word
// 0xaa55 into checksum, signature, x, y, width and height words; a block with a
// matching sum is stored for its signature and a bad sum invalidates it. A query
// (func 1) returns one result item with found and the stored geometry, and
// clears that entry. An accepted item is held in the input register and a
// query's result is then registered in the output register, where it is
// offered; bytes give no result. The input side keeps taking an item every
// cycle while the result register is free or is being drained in the same
// cycle.
module sync_framed_object_block_parser (
  input  logic clk_i,
  input  logic rst_ni,
  sfob_in_if.sink    in_i,
  sfob_out_if.source out_o
);
  import sfob_pkg::*;

  logic       s1_valid_q;
  func_e      s1_func_q;
  logic [7:0] s1_byte_q;
  logic [2:0] s1_sig_q;

  logic    out_valid_q;
  result_t out_q;

  logic    out_free;
  logic    s1_adv;
  logic    byte_en;
  logic    query_en;
  store_t  store;
  result_t result;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_adv   = s1_valid_q && (s1_func_q == FUNC_BYTE || out_free);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign byte_en  = s1_adv && (s1_func_q == FUNC_BYTE);
  assign query_en = s1_adv && (s1_func_q == FUNC_QUERY);

  sfob_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (byte_en),
    .rx_byte_i (s1_byte_q),
    .store_o   (store)
  );

  sfob_table u_table (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .store_i           (store),
    .query_en_i        (query_en),
    .query_signature_i (s1_sig_q),
    .result_o          (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (query_en) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_func_q <= func_e'(in_i.func);
      s1_byte_q <= in_i.rx_byte;
      s1_sig_q  <= in_i.query_signature;
    end
    if (query_en) begin
      out_q <= result;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.found      = out_q.found;
  assign out_o.obj_x      = out_q.geom.x;
  assign out_o.obj_y      = out_q.geom.y;
  assign out_o.obj_width  = out_q.geom.width;
  assign out_o.obj_height = out_q.geom.height;

endmodule
